@@ hdl/tolerance_window_debouncer_defines.svh @@
// ----------------------------------------------------------------------------
// Tolerance window debouncer assertion macros
// Shorthand for the clocked implication checks used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef TOLERANCE_WINDOW_DEBOUNCER_DEFINES_SVH
`define TOLERANCE_WINDOW_DEBOUNCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWDB_ASSERT_NOW(label, clock, reset_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(reset_n)) \
		(ante) |-> (cons)) else $error("twdb check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TWDB_ASSERT_NEXT(label, clock, reset_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(reset_n)) \
		(ante) |=> (cons)) else $error("twdb check failed");

`endif

@@ hdl/twdb_pkg.sv @@
// ----------------------------------------------------------------------------
// Tolerance window debouncer package
// Shared widths, defaults, opcodes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package twdb_pkg;

	// Default parameter values.
	localparam int DEF_READING_WIDTH = 10;
	localparam int DEF_TIME_WIDTH    = 32;

	// Fixed register widths.
	localparam int TOL_WIDTH  = 10;
	localparam int CFG_WIDTH  = 32;
	localparam int ADDR_WIDTH = 4;

	// Register reset values.
	localparam logic [TOL_WIDTH-1:0] TOL_RESET      = TOL_WIDTH'(2);
	localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = CFG_WIDTH'(2000);
	localparam logic [CFG_WIDTH-1:0] INTERVAL_RESET = CFG_WIDTH'(100);

	// Input opcodes.
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} opcode_t;

	// Register indexes (word address bits of paddr).
	typedef enum logic [1:0] {
		REG_TOLERANCE = 2'd0,
		REG_HOLD_TIME = 2'd1,
		REG_INTERVAL  = 2'd2
	} reg_index_t;

endpackage

@@ hdl/tolerance_window_debouncer.sv @@
// ----------------------------------------------------------------------------
// Tolerance window debouncer
// Gates timestamped readings by sample interval and latches a stable value
// once readings stay within tolerance for the hold time; a clear opcode resets it.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while the result side is not stalled and
// returns one result beat for each input beat, in order. A beat passes through
// an input register and then a single pass of compare and subtract logic into
// the result register. The state update and the next beat's use of it meet in
// that one pass, which is what holds the rate at one beat per cycle. The user
// must write the configuration registers on the APB-style port only while the
// stream is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module tolerance_window_debouncer #(
	parameter int READING_WIDTH = twdb_pkg::DEF_READING_WIDTH,
	parameter int TIME_WIDTH    = twdb_pkg::DEF_TIME_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [twdb_pkg::ADDR_WIDTH-1:0]     paddr,
	input  logic [twdb_pkg::CFG_WIDTH-1:0]      pwdata,
	output logic [twdb_pkg::CFG_WIDTH-1:0]      prdata,
	output logic                                pready,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [READING_WIDTH-1:0]            reading,
	input  logic [TIME_WIDTH-1:0]               time_ms,
	// Result channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                accepted,
	output logic                                stable,
	output logic signed [READING_WIDTH:0]       stable_value,
	output logic signed [READING_WIDTH:0]       previous_value,
	output logic [twdb_pkg::CFG_WIDTH-1:0]      stable_time
);

	import twdb_pkg::*;

	// Compare widths wide enough for both operands.
	localparam int CW  = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;
	localparam int RTW = (READING_WIDTH > TOL_WIDTH) ? READING_WIDTH : TOL_WIDTH;

	// Configuration registers.
	logic [TOL_WIDTH-1:0] tol_q;
	logic [CFG_WIDTH-1:0] hold_q;
	logic [CFG_WIDTH-1:0] interval_q;
	logic                 cfg_wr;
	reg_index_t           cfg_idx;

	// Input stage.
	logic                     v_s1;
	opcode_t                  opcode_s1;
	logic [READING_WIDTH-1:0] reading_s1;
	logic [TIME_WIDTH-1:0]    time_s1;

	// Debouncer state.
	logic                     seeded_q;
	logic                     stable_q;
	logic [READING_WIDTH-1:0] prev_q;
	logic [READING_WIDTH-1:0] latched_q;
	logic [TIME_WIDTH-1:0]    since_q;
	logic [TIME_WIDTH-1:0]    last_q;

	// Next state.
	logic                     seeded_n;
	logic                     stable_n;
	logic [READING_WIDTH-1:0] prev_n;
	logic [READING_WIDTH-1:0] latched_n;
	logic [TIME_WIDTH-1:0]    since_n;
	logic [TIME_WIDTH-1:0]    last_n;
	logic                     accepted_n;

	// Result register.
	logic                             out_valid_q;
	logic                             accepted_q;
	logic                             stable_q_out;
	logic signed [READING_WIDTH:0]    stable_value_q;
	logic signed [READING_WIDTH:0]    previous_value_q;
	logic [CFG_WIDTH-1:0]             stable_time_q;

	// Datapath intermediates.
	logic                     fire_s1;
	logic [TIME_WIDTH-1:0]    gap;
	logic [TIME_WIDTH-1:0]    held;
	logic [READING_WIDTH-1:0] delta;
	logic                     skip;
	logic                     steady;
	logic                     held_ok;

	// Configuration write and read decode.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_index_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_TOLERANCE: prdata = CFG_WIDTH'(tol_q);
			REG_HOLD_TIME: prdata = hold_q;
			REG_INTERVAL:  prdata = interval_q;
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= TOL_RESET;
			hold_q     <= HOLD_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_TOLERANCE: tol_q      <= pwdata[TOL_WIDTH-1:0];
				REG_HOLD_TIME: hold_q     <= pwdata;
				REG_INTERVAL:  interval_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage advances whenever the result register frees.
	assign fire_s1  = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1  <= opcode_t'(opcode);
			reading_s1 <= reading;
			time_s1    <= time_ms;
		end
	end

	// Interval gate and hold timer modulo time width, and tolerance compare.
	assign gap     = time_s1 - last_q;
	assign held    = time_s1 - since_q;
	assign delta   = (reading_s1 >= prev_q) ? (reading_s1 - prev_q) : (prev_q - reading_s1);
	assign skip    = seeded_q && (CW'(gap) < CW'(interval_q));
	assign held_ok = CW'(held) >= CW'(hold_q);
	assign steady  = RTW'(delta) <= RTW'(tol_q);

	// Next state for the beat in the input stage.
	always_comb begin
		seeded_n   = seeded_q;
		stable_n   = stable_q;
		prev_n     = prev_q;
		latched_n  = latched_q;
		since_n    = since_q;
		last_n     = last_q;
		accepted_n = 1'b0;
		if (opcode_s1 == OP_CLEAR) begin
			seeded_n = 1'b0;
			stable_n = 1'b0;
		end else if (!skip) begin
			accepted_n = 1'b1;
			last_n     = time_s1;
			prev_n     = reading_s1;
			if (!seeded_q) begin
				seeded_n = 1'b1;
				stable_n = 1'b0;
				since_n  = time_s1;
			end else if (!steady) begin
				stable_n = 1'b0;
				since_n  = time_s1;
			end else if (held_ok) begin
				stable_n  = 1'b1;
				latched_n = reading_s1;
			end
		end
	end

	// State update; value registers are only read once seeded or stable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			stable_q <= 1'b0;
		end else if (fire_s1) begin
			seeded_q <= seeded_n;
			stable_q <= stable_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			prev_q    <= prev_n;
			latched_q <= latched_n;
			since_q   <= since_n;
			last_q    <= last_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			accepted_q       <= accepted_n;
			stable_q_out     <= stable_n;
			stable_value_q   <= stable_n ? $signed({1'b0, latched_n}) : '1;
			previous_value_q <= seeded_n ? $signed({1'b0, prev_n}) : '1;
			stable_time_q    <= stable_n ? hold_q : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = accepted_q;
	assign stable         = stable_q_out;
	assign stable_value   = stable_value_q;
	assign previous_value = previous_value_q;
	assign stable_time    = stable_time_q;

endmodule

@@ hdl/twdb_checker.sv @@
// ----------------------------------------------------------------------------
// Tolerance window debouncer checker
// Port-level checks on the result beats and the flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tolerance_window_debouncer_defines.svh"

module twdb_checker #(
	parameter int READING_WIDTH = twdb_pkg::DEF_READING_WIDTH
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          accepted,
	input logic                          stable,
	input logic signed [READING_WIDTH:0] stable_value,
	input logic signed [READING_WIDTH:0] previous_value,
	input logic [twdb_pkg::CFG_WIDTH-1:0] stable_time
);

	import twdb_pkg::*;

	// A stalled result beat holds its payload.
	`TWDB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(stable_value) && $stable(previous_value) && $stable(stable_time))

	// Input back-pressure only comes from a stalled result.
	`TWDB_ASSERT_NOW(a_in_stall, clk, arst_n, !in_ready, out_valid && !out_ready)

	// A used or stable sample implies a seeded previous reading.
	`TWDB_ASSERT_NOW(a_seeded, clk, arst_n, out_valid && (accepted || stable),
		previous_value != '1)

	// Not stable reports the idle markers.
	`TWDB_ASSERT_NOW(a_unstable, clk, arst_n, out_valid && !stable,
		stable_value == '1 && stable_time == '0)

endmodule

bind tolerance_window_debouncer twdb_checker #(
	.READING_WIDTH(READING_WIDTH)
) u_twdb_checker (.*);
